// ===== sv/kdlp_pkg.sv =====
package kdlp_pkg;

  localparam int unsigned NUM_KEYS   = 4;
  localparam int unsigned DEB_W      = 4;
  localparam int unsigned HOLD_W     = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [DEB_W-1:0]  DEB_TICKS_RST  = 4'd3;
  localparam logic [HOLD_W-1:0] LONG_TICKS_RST = 10'd200;

  // key positions in the pin vector
  localparam int unsigned KEY_PREV = 0;
  localparam int unsigned KEY_NEXT = 1;
  localparam int unsigned KEY_ADJ  = 2;
  localparam int unsigned KEY_ITEM = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 1'd0,
    REG_LONG_PRESS = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    EV_NONE  = 4'd0,
    EV_PREV  = 4'd1,
    EV_NEXT  = 4'd2,
    EV_ITEM  = 4'd3,
    EV_INC   = 4'd4,
    EV_DEC   = 4'd5,
    EV_RUN   = 4'd6,
    EV_SAVE  = 4'd7,
    EV_CLEAN = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_CLEAN = 2'd2
  } mode_t;

  // per-tick side inputs for the event logic
  typedef struct packed {
    logic dir;
    logic can_run;
    logic take;
  } tick_ctl_t;

endpackage

// ===== sv/kdlp_debounce.sv =====
module kdlp_debounce
  import kdlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [NUM_KEYS-1:0] pins,
  input  logic [DEB_W-1:0]    deb_ticks,
  output logic [NUM_KEYS-1:0] stable_now
);

  logic [NUM_KEYS-1:0] raw_r, raw_nxt;
  logic [NUM_KEYS-1:0] stable_r, stable_nxt;
  logic [DEB_W-1:0]    cnt_r [NUM_KEYS];
  logic [DEB_W-1:0]    cnt_nxt [NUM_KEYS];
  logic [DEB_W-1:0]    deb_eff;
  logic [NUM_KEYS-1:0] cur;

  // a setting of zero behaves as one
  assign deb_eff = (deb_ticks == '0) ? DEB_W'(1) : deb_ticks;
  assign cur     = ~pins;

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    for (int i = 0; i < NUM_KEYS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (cur[i] != raw_r[i]) begin
        raw_nxt[i] = cur[i];
        cnt_nxt[i] = deb_eff;
      end else if (cnt_r[i] != '0) begin
        cnt_nxt[i] = cnt_r[i] - DEB_W'(1);
        if (cnt_r[i] == DEB_W'(1)) begin
          stable_nxt[i] = raw_r[i];
        end
      end
    end
  end

  assign stable_now = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '1;
      stable_r <= '1;
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (adv) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

// ===== sv/kdlp_events.sv =====
module kdlp_events
  import kdlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [NUM_KEYS-1:0] sp,
  input  tick_ctl_t           ctl,
  input  logic [HOLD_W-1:0]   long_ticks,
  output event_t              ev_report,
  output mode_t               mode_report
);

  logic [NUM_KEYS-1:0] was_r;
  logic [HOLD_W-1:0]   hold_r [2];
  logic [HOLD_W-1:0]   hold_nxt [2];
  logic [1:0]          ld_r, ld_nxt;
  logic [1:0]          ct_r, ct_nxt;
  logic [HOLD_W-1:0]   cc_r, cc_nxt;
  logic                cd_r, cd_nxt;
  mode_t               mode_r, mode_nxt;
  event_t              latch_r, latch_nxt;

  logic       both;
  logic       clean_fire;
  logic [1:0] page_fire;
  logic [1:0] page_short;
  logic       adj_edge, item_edge;
  event_t     ev_new;
  event_t     ev_cur;

  assign both      = sp[KEY_PREV] & sp[KEY_NEXT];
  assign adj_edge  = sp[KEY_ADJ] & ~was_r[KEY_ADJ];
  assign item_edge = sp[KEY_ITEM] & ~was_r[KEY_ITEM];

  always_comb begin
    logic k;
    logic ko;
    cc_nxt     = cc_r;
    cd_nxt     = cd_r;
    ld_nxt     = ld_r;
    ct_nxt     = ct_r;
    mode_nxt   = mode_r;
    clean_fire = 1'b0;
    page_fire  = 2'b00;
    page_short = 2'b00;
    hold_nxt[0] = hold_r[0];
    hold_nxt[1] = hold_r[1];

    if (both) begin
      ct_nxt = 2'b11;
      if (cc_r < long_ticks) begin
        cc_nxt = cc_r + HOLD_W'(1);
      end
      if (cc_nxt >= long_ticks && !cd_r) begin
        clean_fire = 1'b1;
        cd_nxt     = 1'b1;
        ld_nxt     = 2'b11;
        mode_nxt   = MODE_CLEAN;
      end
    end else begin
      cc_nxt = '0;
      cd_nxt = 1'b0;
    end

    // page keys; nothing here while both are held
    for (int i = 0; i < 2; i++) begin
      k  = i[0];
      ko = ~k;
      if (sp[k] && !sp[ko]) begin
        if (!was_r[k]) begin
          hold_nxt[k] = '0;
          ld_nxt[k]   = 1'b0;
          ct_nxt[k]   = 1'b0;
        end else if (hold_r[k] < long_ticks) begin
          hold_nxt[k] = hold_r[k] + HOLD_W'(1);
        end
        if (hold_nxt[k] >= long_ticks && !ld_nxt[k]) begin
          ld_nxt[k]    = 1'b1;
          page_fire[k] = 1'b1;
        end
      end else if (!sp[k] && was_r[k]) begin
        page_short[k] = ~ld_r[k] & ~ct_r[k];
        hold_nxt[k]   = '0;
        ld_nxt[k]     = 1'b0;
        ct_nxt[k]     = 1'b0;
      end
    end

    if (page_fire[0]) begin
      if (mode_r != MODE_STOP) begin
        mode_nxt = MODE_STOP;
      end else begin
        mode_nxt = ctl.can_run ? MODE_RUN : MODE_STOP;
      end
    end
  end

  // first event posted this tick, in posting order
  always_comb begin
    ev_new = EV_NONE;
    if (adj_edge) begin
      ev_new = ctl.dir ? EV_INC : EV_DEC;
    end else if (item_edge) begin
      ev_new = EV_ITEM;
    end else if (clean_fire) begin
      ev_new = EV_CLEAN;
    end else if (page_fire[0]) begin
      ev_new = EV_RUN;
    end else if (page_short[0]) begin
      ev_new = EV_PREV;
    end else if (page_fire[1]) begin
      ev_new = EV_SAVE;
    end else if (page_short[1]) begin
      ev_new = EV_NEXT;
    end
  end

  assign ev_cur      = (latch_r != EV_NONE) ? latch_r : ev_new;
  assign latch_nxt   = ctl.take ? EV_NONE : ev_cur;
  assign ev_report   = ev_cur;
  assign mode_report = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_r     <= '0;
      hold_r[0] <= '0;
      hold_r[1] <= '0;
      ld_r      <= '0;
      ct_r      <= '0;
      cc_r      <= '0;
      cd_r      <= 1'b0;
      mode_r    <= MODE_STOP;
      latch_r   <= EV_NONE;
    end else if (adv) begin
      was_r     <= sp;
      hold_r[0] <= hold_nxt[0];
      hold_r[1] <= hold_nxt[1];
      ld_r      <= ld_nxt;
      ct_r      <= ct_nxt;
      cc_r      <= cc_nxt;
      cd_r      <= cd_nxt;
      mode_r    <= mode_nxt;
      latch_r   <= latch_nxt;
    end
  end

endmodule

// ===== sv/key_debounce_long_press_events_core.sv =====
// Key debounce and long-press event detector.
// Input channel (in_*): one transaction per scan tick with the four active-low
// key levels, the direction switch, the can-run flag and the consume strobe.
// Output channel (out_*): one transaction per scan tick with the pending event
// (latched content before this tick's consume), the run mode and the
// debounced key flags.
// Config channel (cfg_*): always ready; index 0 sets debounce ticks, index 1
// sets long-press ticks. Write only while no tick is in flight.
// Flow: a tick accepted into the input register is processed and lands in the
// output register, which raises out_valid. Throughput: one tick per cycle while
// the output is not stalled, set by the single state update between the input
// and output registers.
// Reset: debounce 3, long press 200; all keys count as pressed and were not
// pressed before, so the first tick sees a press edge on every key.
// Stall: the output register holds its result while out_ready is low, the
// input register holds one more tick, then in_ready drops.
module key_debounce_long_press_events_core
  import kdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            in_key_pins,
  input  logic                  in_direction_pin,
  input  logic                  in_can_run,
  input  logic                  in_take_event,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_pending_event,
  output logic [1:0]            out_run_mode,
  output logic [3:0]            out_keys_stable,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DEB_W-1:0]    deb_r;
  logic [HOLD_W-1:0]   long_r;

  logic                iv_r;
  logic [NUM_KEYS-1:0] pins_r;
  tick_ctl_t           ctl_r;

  logic                ov_r;
  event_t              ev_out_r;
  mode_t               mode_out_r;
  logic [NUM_KEYS-1:0] stable_out_r;

  logic                adv;
  logic [NUM_KEYS-1:0] stable_now;
  event_t              ev_report;
  mode_t               mode_report;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DEB_TICKS_RST;
      long_r <= LONG_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:   deb_r  <= cfg_data[DEB_W-1:0];
        REG_LONG_PRESS: long_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // process the held tick when the output register is free or being emptied
  assign adv      = iv_r & (~ov_r | out_ready);
  assign in_ready = ~iv_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_ready) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pins_r        <= in_key_pins;
      ctl_r.dir     <= in_direction_pin;
      ctl_r.can_run <= in_can_run;
      ctl_r.take    <= in_take_event;
    end
  end

  kdlp_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .pins       (pins_r),
    .deb_ticks  (deb_r),
    .stable_now (stable_now)
  );

  kdlp_events u_events (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .sp          (stable_now),
    .ctl         (ctl_r),
    .long_ticks  (long_r),
    .ev_report   (ev_report),
    .mode_report (mode_report)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_out_r     <= ev_report;
      mode_out_r   <= mode_report;
      stable_out_r <= stable_now;
    end
  end

  assign out_valid         = ov_r;
  assign out_pending_event = ev_out_r;
  assign out_run_mode      = mode_out_r;
  assign out_keys_stable   = stable_out_r;

endmodule

// ===== dv/key_debounce_long_press_events_core_tb.sv =====
`timescale 1ns / 1ps

module key_debounce_long_press_events_core_tb;
  import kdlp_pkg::*;

  typedef struct {
    event_t     ev;
    mode_t      mode;
    logic [3:0] keys;
  } scan_report_t;

  typedef enum int {G_TAP, G_HOLD, G_COMBO, G_NOISE} gesture_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [3:0]            in_key_pins;
  logic                  in_direction_pin;
  logic                  in_can_run;
  logic                  in_take_event;
  logic                  out_valid;
  logic                  out_ready;
  logic [3:0]            out_pending_event;
  logic [1:0]            out_run_mode;
  logic [3:0]            out_keys_stable;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  key_debounce_long_press_events_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_pins       (in_key_pins),
    .in_direction_pin  (in_direction_pin),
    .in_can_run        (in_can_run),
    .in_take_event     (in_take_event),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pending_event (out_pending_event),
    .out_run_mode      (out_run_mode),
    .out_keys_stable   (out_keys_stable),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // shadow of the block's configuration and scan state (reset values)
  logic [DEB_W-1:0]  deb_ticks  = DEB_TICKS_RST;
  logic [HOLD_W-1:0] long_ticks = LONG_TICKS_RST;
  logic [3:0]        raw_p      = 4'hF;
  logic [3:0]        stab_p     = 4'hF;
  logic [3:0]        was_p      = 4'h0;
  logic [DEB_W-1:0]  settle_cnt [NUM_KEYS];
  logic [HOLD_W-1:0] hold_cnt [2];
  logic [1:0]        long_fired = 2'b00;
  logic [1:0]        combo_seen = 2'b00;
  logic [HOLD_W-1:0] combo_cnt  = '0;
  logic              combo_fired = 1'b0;
  mode_t             run_mode_m = MODE_STOP;
  event_t            latched_ev = EV_NONE;

  scan_report_t expected_scan_reports[$];
  int           mismatch_count = 0;
  int           ticks_sent = 0;
  bit           steady_flow = 0;

  initial begin
    foreach (settle_cnt[i]) settle_cnt[i] = '0;
    foreach (hold_cnt[i]) hold_cnt[i] = '0;
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void latch_event(input event_t ev);
    if (ev != EV_NONE && latched_ev == EV_NONE) latched_ev = ev;
  endfunction

  task automatic page_key_step(input int k, input int o, input logic can_run);
    if (stab_p[k] && !stab_p[o]) begin
      if (!was_p[k]) begin
        hold_cnt[k] = '0;
        long_fired[k] = 1'b0;
        combo_seen[k] = 1'b0;
      end else if (hold_cnt[k] < long_ticks) begin
        hold_cnt[k] = hold_cnt[k] + 1'b1;
      end
      if (hold_cnt[k] >= long_ticks && !long_fired[k]) begin
        long_fired[k] = 1'b1;
        if (k == KEY_PREV) begin
          if (run_mode_m != MODE_STOP) run_mode_m = MODE_STOP;
          else run_mode_m = can_run ? MODE_RUN : MODE_STOP;
          latch_event(EV_RUN);
        end else begin
          latch_event(EV_SAVE);
        end
      end
    end else if (!stab_p[k] && was_p[k]) begin
      // short press only: long hold or combo suppresses the page event
      if (!long_fired[k] && !combo_seen[k]) latch_event(k == KEY_PREV ? EV_PREV : EV_NEXT);
      hold_cnt[k] = '0;
      long_fired[k] = 1'b0;
      combo_seen[k] = 1'b0;
    end
  endtask

  task automatic compute_scan_report(input logic [3:0] pins, input logic dir,
                                     input logic can_run, input logic take);
    scan_report_t rep;
    logic [DEB_W-1:0] deb;
    logic cur;
    int i;
    deb = (deb_ticks == 0) ? 4'd1 : deb_ticks;
    for (i = 0; i < NUM_KEYS; i++) begin
      cur = ~pins[i];
      if (cur != raw_p[i]) begin
        raw_p[i] = cur;
        settle_cnt[i] = deb;
      end else if (settle_cnt[i] != 0) begin
        settle_cnt[i] = settle_cnt[i] - 1'b1;
        if (settle_cnt[i] == 0) stab_p[i] = raw_p[i];
      end
    end
    if (stab_p[KEY_ADJ] && !was_p[KEY_ADJ]) latch_event(dir ? EV_INC : EV_DEC);
    if (stab_p[KEY_ITEM] && !was_p[KEY_ITEM]) latch_event(EV_ITEM);
    if (stab_p[KEY_PREV] && stab_p[KEY_NEXT]) begin
      combo_seen = 2'b11;
      if (combo_cnt < long_ticks) combo_cnt = combo_cnt + 1'b1;
      if (combo_cnt >= long_ticks && !combo_fired) begin
        combo_fired = 1'b1;
        long_fired = 2'b11;
        run_mode_m = MODE_CLEAN;
        latch_event(EV_CLEAN);
      end
    end else begin
      combo_cnt = '0;
      combo_fired = 1'b0;
    end
    page_key_step(KEY_PREV, KEY_NEXT, can_run);
    page_key_step(KEY_NEXT, KEY_PREV, can_run);
    was_p = stab_p;
    rep.ev = latched_ev;
    rep.mode = run_mode_m;
    rep.keys = stab_p;
    expected_scan_reports.push_back(rep);
    if (take) latched_ev = EV_NONE;
  endtask

  // one scan tick on the input channel
  task automatic send_tick(input logic [3:0] pins, input logic dir,
                           input logic can_run, input logic take);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_key_pins <= pins;
    in_direction_pin <= dir;
    in_can_run <= can_run;
    in_take_event <= take;
    do @(posedge clk); while (!in_ready);
    compute_scan_report(pins, dir, can_run, take);
    ticks_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scan_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] lp);
    logic [5:0] junk;
    junk = 6'($urandom_range(0, 63));
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= {junk, deb};
    do @(posedge clk); while (!cfg_ready);
    deb_ticks = deb;
    @(negedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= lp;
    do @(posedge clk); while (!cfg_ready);
    long_ticks = lp;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fixed control fields, consume only on the last tick if asked
  task automatic press_for(input logic [3:0] pins, input int n, input logic dir,
                           input logic can_run, input logic take_last);
    int t;
    for (t = 0; t < n; t++) send_tick(pins, dir, can_run, take_last && (t == n - 1));
  endtask

  // hold a key set with random control fields and some contact bounce up front
  task automatic hold_keys(input logic [3:0] mask, input int n);
    int t;
    int bounce;
    logic [3:0] pins;
    bounce = $urandom_range(0, 2);
    for (t = 0; t < n; t++) begin
      pins = ~mask;
      if (t < bounce) pins = pins ^ 4'($urandom_range(0, 15));
      send_tick(pins, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic play_gesture(input gesture_t kind);
    int deb_eff;
    int short_max;
    int len;
    logic [3:0] mask;
    deb_eff = (deb_ticks == 0) ? 1 : deb_ticks;
    short_max = (long_ticks > 1) ? ((long_ticks - 1 > 40) ? 40 : long_ticks - 1) : 0;
    len = 0;
    mask = 4'b0000;
    case (kind)
      G_TAP: begin
        if ($urandom_range(0, 3) == 0) mask = 4'($urandom_range(1, 15));
        else mask = 4'b0001 << $urandom_range(0, 3);
        len = deb_eff + $urandom_range(0, short_max);
      end
      G_HOLD: begin
        mask = $urandom_range(0, 1) ? 4'b0010 : 4'b0001;
        len = deb_eff + long_ticks + $urandom_range(1, 4);
      end
      G_COMBO: begin
        mask = 4'b0011;
        len = deb_eff + long_ticks + $urandom_range(1, 4);
      end
      default: begin
        repeat ($urandom_range(1, 8))
          send_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    endcase
    if (len > 0) hold_keys(mask, len);
    hold_keys(4'b0000, deb_eff + $urandom_range(1, 4));
  endtask

  task automatic run_phase(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] lp,
                           input int budget, input gesture_t first, input bit quiet);
    int start;
    int roll;
    write_config(deb, lp);
    steady_flow = quiet;
    start = ticks_sent;
    play_gesture(first);
    while (ticks_sent - start < budget) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) play_gesture(G_TAP);
      else if (roll < 6) play_gesture(G_HOLD);
      else if (roll < 8) play_gesture(G_COMBO);
      else play_gesture(G_NOISE);
    end
    steady_flow = 0;
  endtask

  // all keys look pressed out of reset; releasing them must not post page events
  task automatic test_reset_edges;
    press_for(4'hF, 4, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_zero_thresholds;
    write_config(4'd0, 10'd0);
    press_for(4'b1110, 2, 1'b0, 1'b1, 1'b0);   // run toggle, stop -> run
    press_for(4'hF, 2, 1'b0, 1'b1, 1'b1);
    press_for(4'b1100, 2, 1'b1, 1'b0, 1'b0);   // clean
    press_for(4'hF, 2, 1'b1, 1'b0, 1'b0);
    press_for(4'b1101, 2, 1'b0, 1'b0, 1'b1);   // save dropped while latch is full
    press_for(4'hF, 2, 1'b0, 1'b0, 1'b0);
    press_for(4'b1110, 2, 1'b1, 1'b0, 1'b0);   // clean -> stop
    press_for(4'hF, 2, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_short_taps;
    write_config(4'd1, 10'd1023);
    press_for(4'b0011, 2, 1'b0, 1'b1, 1'b0);   // dec wins, item dropped
    press_for(4'hF, 2, 1'b0, 1'b1, 1'b1);
    press_for(4'b1110, 2, 1'b1, 1'b0, 1'b0);
    press_for(4'hF, 2, 1'b1, 1'b0, 1'b1);      // short prev on release
  endtask

  task automatic test_random_gestures;
    run_phase(4'd1, 10'd6, 130, G_HOLD, 0);
    run_phase(4'd0, 10'd0, 130, G_COMBO, 1);
    run_phase(4'd2, 10'd15, 130, G_HOLD, 0);
    run_phase(4'd15, 10'd100, 1, G_COMBO, 0);
    run_phase(DEB_TICKS_RST, LONG_TICKS_RST, 230, G_HOLD, 1);
    run_phase(4'd1, 10'd1, 130, G_TAP, 0);
    run_phase(4'd5, 10'd40, 130, G_COMBO, 0);
  endtask

  // result side: random back-pressure, compare against the oldest prediction
  initial begin
    int stall;
    scan_report_t rep;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_scan_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, event %0d mode %0d keys %h",
                                  out_pending_event, out_run_mode, out_keys_stable));
      end else begin
        rep = expected_scan_reports.pop_front();
        if (out_pending_event !== rep.ev)
          report_mismatch($sformatf("pending_event got %0d expected %0d",
                                    out_pending_event, rep.ev));
        if (out_run_mode !== rep.mode)
          report_mismatch($sformatf("run_mode got %0d expected %0d", out_run_mode, rep.mode));
        if (out_keys_stable !== rep.keys)
          report_mismatch($sformatf("keys_stable got %h expected %h",
                                    out_keys_stable, rep.keys));
      end
    end
  end

  initial begin
    int guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key_pins = 4'hF;
    in_direction_pin = 1'b0;
    in_can_run = 1'b0;
    in_take_event = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_edges();
    test_zero_thresholds();
    test_short_taps();
    test_random_gestures();

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_scan_reports.size() != 0 && guard < 500) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (expected_scan_reports.size() != 0)
      report_mismatch($sformatf("%0d transactions never arrived", expected_scan_reports.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
